FILE: hdl/vmt_pkg.sv
// ----------------------------------------------------------------------------
// vmt_pkg
// Shared types and constants of the voltmeter min/max/average tracker.
// ----------------------------------------------------------------------------
package vmt_pkg;

    // Width of every converted value in hundredths of a volt.
    localparam int CV_W  = 10;
    // Width of the keypad code and of the configuration data.
    localparam int KEY_W = 5;
    localparam int CFG_DATA_W  = 10;
    localparam int CFG_INDEX_W = 1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FULL_SCALE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TOGGLE_KEY = 1'b1;

    // Register values after reset.
    localparam logic [CV_W-1:0]  FULL_SCALE_RESET = 10'd500;
    localparam logic [KEY_W-1:0] TOGGLE_KEY_RESET = 5'd4;

    // Key code that means no key pressed.
    localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;

    // Operation field of an input word.
    localparam logic OPERATION_SAMPLE = 1'b0;

    // Classified command handed from the front to the back.
    typedef enum logic [1:0] {
        OP_NOP    = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_TOGGLE = 2'd2
    } t_op;

    // Measurement mode as shown on the result ports.
    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_ARMED   = 2'd1,
        MODE_RUNNING = 2'd2,
        MODE_PAUSED  = 2'd3
    } t_mode;

    // Conversion jobs run for each result.
    typedef enum logic [1:0] {
        JOB_INSTANT = 2'd0,
        JOB_MAX     = 2'd1,
        JOB_MIN     = 2'd2,
        JOB_AVERAGE = 2'd3
    } t_job;

    // Control handshake of the command queue towards the back.
    typedef struct packed {
        logic valid;
        t_op  op;
    } t_cmd_ctl;

    // One result word.
    typedef struct packed {
        t_mode           mode;
        logic            instant_valid;
        logic            stats_valid;
        logic [CV_W-1:0] instant_cv;
        logic [CV_W-1:0] max_cv;
        logic [CV_W-1:0] min_cv;
        logic [CV_W-1:0] average_cv;
        logic            count_saturated;
    } t_result;

endpackage

FILE: hdl/vmt_front.sv
// ----------------------------------------------------------------------------
// vmt_front
// Accepts input words, classifies them into commands and queues them.
// ----------------------------------------------------------------------------
module vmt_front #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input channel
    input  logic                         i_push,
    output logic                         o_full,
    input  logic                         i_operation,
    input  logic [SAMPLE_BITS-1:0]       i_sample_code,
    input  logic [vmt_pkg::KEY_W-1:0]    i_key_code,
    input  logic [vmt_pkg::KEY_W-1:0]    i_toggle_key,
    // Command queue towards the back
    output vmt_pkg::t_cmd_ctl            o_cmd,
    output logic [SAMPLE_BITS-1:0]       o_cmd_code,
    input  logic                         i_cmd_pop
);

    localparam int DEPTH = 2;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vmt_pkg::t_op               r_q_op   [DEPTH];
    logic [SAMPLE_BITS-1:0]     r_q_code [DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [CNT_W-1:0]           r_count;

    vmt_pkg::t_op               op_class;
    logic                       push_acc;
    logic                       pop_acc;

    // Classify the word: samples, the toggle key, and everything else.
    always_comb begin
        if (i_operation == vmt_pkg::OPERATION_SAMPLE) begin
            op_class = vmt_pkg::OP_SAMPLE;
        end else if (i_key_code != vmt_pkg::KEY_NONE && i_key_code == i_toggle_key) begin
            op_class = vmt_pkg::OP_TOGGLE;
        end else begin
            op_class = vmt_pkg::OP_NOP;
        end
    end

    assign o_full   = (r_count == CNT_W'(DEPTH));
    assign push_acc = i_push && !o_full;
    assign pop_acc  = i_cmd_pop && (r_count != '0);

    assign o_cmd.valid = (r_count != '0);
    assign o_cmd.op    = r_q_op[r_rd_ptr];
    assign o_cmd_code  = r_q_code[r_rd_ptr];

    // Queue storage; the entries themselves carry no reset.
    always_ff @(posedge i_clk) begin
        if (push_acc) begin
            r_q_op[r_wr_ptr]   <= op_class;
            r_q_code[r_wr_ptr] <= i_sample_code;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_acc) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_acc) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_acc && !pop_acc) begin
                r_count <= r_count + 1'b1;
            end else if (pop_acc && !push_acc) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/vmt_div.sv
// ----------------------------------------------------------------------------
// vmt_div
// Scales a code total to hundredths of a volt with rounding, using one
// multiply and a restoring divider that yields one quotient bit a cycle.
// ----------------------------------------------------------------------------
module vmt_div #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [SAMPLE_BITS+COUNT_BITS-1:0]      i_total,
    input  logic [COUNT_BITS-1:0]                  i_n,
    input  logic [vmt_pkg::CV_W-1:0]               i_full_scale,
    output logic                                   o_done,
    output logic [vmt_pkg::CV_W-1:0]               o_quot
);

    localparam int Q_W    = vmt_pkg::CV_W;
    localparam int SUM_W  = SAMPLE_BITS + COUNT_BITS;
    localparam int DEN_W  = SUM_W;
    localparam int PROD_W = SUM_W + Q_W;
    localparam int NUM_W  = PROD_W + 2;
    localparam int STEP_W = $clog2(Q_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_ADD,
        D_DIV
    } t_dstate;

    t_dstate            r_state;
    logic               r_done;
    logic [PROD_W-1:0]  r_prod;
    logic [DEN_W-1:0]   r_den;
    logic [NUM_W-1:0]   r_rem;
    logic [PROD_W-1:0]  r_dsh;
    logic [Q_W-1:0]     r_quot;
    logic               r_zero;
    logic [STEP_W-1:0]  r_step;

    logic               ge;

    // The quotient never exceeds the full-scale value, so Q_W steps suffice.
    assign ge     = (r_rem >= NUM_W'(r_dsh));
    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

    // Sequencer and datapath: multiply, form the rounded numerator, divide.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_prod  <= PROD_W'(i_total) * PROD_W'(i_full_scale);
                        r_den   <= (DEN_W'(i_n) << SAMPLE_BITS) - DEN_W'(i_n);
                        r_state <= D_ADD;
                    end
                end
                D_ADD: begin
                    // Numerator 2*total*fs + den over divisor 2*den rounds halves up.
                    r_rem   <= {1'b0, r_prod, 1'b0} + NUM_W'(r_den);
                    r_dsh   <= PROD_W'({r_den, 1'b0}) << (Q_W - 1);
                    r_zero  <= (r_den == '0);
                    r_step  <= STEP_W'(Q_W - 1);
                    r_state <= D_DIV;
                end
                D_DIV: begin
                    if (ge) begin
                        r_rem <= r_rem - NUM_W'(r_dsh);
                    end
                    r_quot <= {r_quot[Q_W-2:0], ge};
                    r_dsh  <= r_dsh >> 1;
                    if (r_step == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/vmt_back.sv
// ----------------------------------------------------------------------------
// vmt_back
// Carries out queued commands: runs the mode machine, keeps the run
// statistics, converts them and holds the result word for the receiver.
// ----------------------------------------------------------------------------
module vmt_back #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  vmt_pkg::t_cmd_ctl              i_cmd,
    input  logic [SAMPLE_BITS-1:0]         i_cmd_code,
    output logic                           o_cmd_pop,
    input  logic [vmt_pkg::CV_W-1:0]       i_full_scale,
    output vmt_pkg::t_result               o_result,
    output logic                           o_result_valid,
    input  logic                           i_result_pop
);

    localparam int SUM_W = SAMPLE_BITS + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam int CV_W = vmt_pkg::CV_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_WAIT,
        S_OUT
    } t_state;

    t_state                   r_state;
    vmt_pkg::t_mode           r_mode;
    logic [SAMPLE_BITS-1:0]   r_last;
    logic [SAMPLE_BITS-1:0]   r_min;
    logic [SAMPLE_BITS-1:0]   r_max;
    logic [SUM_W-1:0]         r_sum;
    logic [COUNT_BITS-1:0]    r_count;
    vmt_pkg::t_job            r_job;
    logic [CV_W-1:0]          r_cv [4];
    vmt_pkg::t_result         r_out;
    logic                     r_out_valid;

    logic [SUM_W-1:0]         job_total;
    logic [COUNT_BITS-1:0]    job_n;
    logic                     div_start;
    logic                     div_done;
    logic [CV_W-1:0]          div_quot;
    logic                     running;
    logic                     shown;

    assign o_cmd_pop      = (r_state == S_IDLE) && i_cmd.valid;
    assign div_start      = (r_state == S_CONV);
    assign o_result       = r_out;
    assign o_result_valid = r_out_valid;
    assign running        = (r_mode == vmt_pkg::MODE_RUNNING);
    assign shown          = running || (r_mode == vmt_pkg::MODE_PAUSED);

    // Operands of the conversion job in hand.
    always_comb begin
        unique case (r_job)
            vmt_pkg::JOB_INSTANT: begin
                job_total = SUM_W'(r_last);
                job_n     = COUNT_BITS'(1);
            end
            vmt_pkg::JOB_MAX: begin
                job_total = SUM_W'(r_max);
                job_n     = COUNT_BITS'(1);
            end
            vmt_pkg::JOB_MIN: begin
                job_total = SUM_W'(r_min);
                job_n     = COUNT_BITS'(1);
            end
            default: begin
                job_total = r_sum;
                job_n     = r_count;
            end
        endcase
    end

    vmt_div #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (div_start),
        .i_total      (job_total),
        .i_n          (job_n),
        .i_full_scale (i_full_scale),
        .o_done       (div_done),
        .o_quot       (div_quot)
    );

    // Command sequencer, run statistics and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= vmt_pkg::MODE_IDLE;
            r_last      <= '0;
            r_min       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_job       <= vmt_pkg::JOB_INSTANT;
            r_out_valid <= 1'b0;
        end else begin
            // A popped word leaves, unless a new one is loaded in its place.
            if (i_result_pop && r_out_valid && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.valid) begin
                        case (i_cmd.op)
                            vmt_pkg::OP_SAMPLE: begin
                                case (r_mode)
                                    vmt_pkg::MODE_ARMED: begin
                                        r_last  <= i_cmd_code;
                                        r_min   <= i_cmd_code;
                                        r_max   <= i_cmd_code;
                                        r_sum   <= SUM_W'(i_cmd_code);
                                        r_count <= COUNT_BITS'(1);
                                        r_mode  <= vmt_pkg::MODE_RUNNING;
                                    end
                                    vmt_pkg::MODE_RUNNING: begin
                                        r_last <= i_cmd_code;
                                        if (i_cmd_code < r_min) begin
                                            r_min <= i_cmd_code;
                                        end
                                        if (i_cmd_code > r_max) begin
                                            r_max <= i_cmd_code;
                                        end
                                        // Sum and count freeze once the count saturates.
                                        if (r_count != COUNT_MAX) begin
                                            r_sum   <= r_sum + SUM_W'(i_cmd_code);
                                            r_count <= r_count + 1'b1;
                                        end
                                    end
                                    vmt_pkg::MODE_PAUSED: begin
                                        r_last <= i_cmd_code;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            vmt_pkg::OP_TOGGLE: begin
                                case (r_mode) inside
                                    vmt_pkg::MODE_IDLE, vmt_pkg::MODE_PAUSED: begin
                                        r_mode <= vmt_pkg::MODE_ARMED;
                                    end
                                    vmt_pkg::MODE_RUNNING: begin
                                        r_mode <= vmt_pkg::MODE_PAUSED;
                                    end
                                    default: begin
                                    end
                                endcase
                            end
                            default: begin
                            end
                        endcase
                        r_job   <= vmt_pkg::JOB_INSTANT;
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (div_done) begin
                        r_cv[r_job] <= div_quot;
                        if (r_job == vmt_pkg::JOB_AVERAGE) begin
                            r_state <= S_OUT;
                        end else begin
                            r_job   <= vmt_pkg::t_job'(r_job + 2'd1);
                            r_state <= S_CONV;
                        end
                    end
                end
                S_OUT: begin
                    // Load the result once the previous word has left.
                    if (!r_out_valid || i_result_pop) begin
                        r_out.mode            <= r_mode;
                        r_out.instant_valid   <= shown;
                        r_out.stats_valid     <= running;
                        r_out.instant_cv      <= shown ? r_cv[vmt_pkg::JOB_INSTANT] : '0;
                        r_out.max_cv          <= running ? r_cv[vmt_pkg::JOB_MAX] : '0;
                        r_out.min_cv          <= running ? r_cv[vmt_pkg::JOB_MIN] : '0;
                        r_out.average_cv      <= running ? r_cv[vmt_pkg::JOB_AVERAGE] : '0;
                        r_out.count_saturated <= running && (r_count == COUNT_MAX);
                        r_out_valid           <= 1'b1;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: hdl/voltmeter_min_max_average_tracker.sv
// ----------------------------------------------------------------------------
// voltmeter_min_max_average_tracker
// Running minimum, maximum and average of converter samples, in centivolts.
// ----------------------------------------------------------------------------
// Input words (operation, sample_code, key_code) enter on push while full is
// low; each word yields exactly one result word, in order. Results are shown
// while empty is low and leave on pop. A two-word command queue parts the
// input side from the execution side, and the back keeps one result register,
// so new words are taken while a result waits for the receiver.
// In the back, each word first updates the mode and statistics, then runs
// four conversions (instant, max, min, average) on one shared
// multiply-and-divide unit, each a multiply, a rounding add, ten quotient
// bits at one bit a cycle and the hand-over of the quotient, and last loads
// the result. The back finishes one word before it takes the next.
// When the receiver stalls, the held result stays put, the next word is still
// worked out and then waits, and full rises once the queue fills.
// Configuration writes on the cfg channel are always ready and must be made
// while the block is idle. Reset empties the queue and the result register,
// sets the mode to idle, clears the statistics and restores the registers.
// ----------------------------------------------------------------------------
module voltmeter_min_max_average_tracker #(
    parameter int SAMPLE_BITS = 10,
    parameter int COUNT_BITS  = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input channel
    input  logic                                  push,
    output logic                                  full,
    input  logic                                  i_operation,
    input  logic [SAMPLE_BITS-1:0]                i_sample_code,
    input  logic [vmt_pkg::KEY_W-1:0]             i_key_code,
    // Result channel
    output logic                                  empty,
    input  logic                                  pop,
    output logic [1:0]                            o_mode,
    output logic                                  o_instant_valid,
    output logic                                  o_stats_valid,
    output logic [vmt_pkg::CV_W-1:0]              o_instant_centivolts,
    output logic [vmt_pkg::CV_W-1:0]              o_max_centivolts,
    output logic [vmt_pkg::CV_W-1:0]              o_min_centivolts,
    output logic [vmt_pkg::CV_W-1:0]              o_average_centivolts,
    output logic                                  o_count_saturated,
    // Configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [vmt_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [vmt_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    logic [vmt_pkg::CV_W-1:0]   r_full_scale;
    logic [vmt_pkg::KEY_W-1:0]  r_toggle_key;

    vmt_pkg::t_cmd_ctl          cmd;
    logic [SAMPLE_BITS-1:0]     cmd_code;
    logic                       cmd_pop;
    vmt_pkg::t_result           result;
    logic                       result_valid;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= vmt_pkg::FULL_SCALE_RESET;
            r_toggle_key <= vmt_pkg::TOGGLE_KEY_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                vmt_pkg::CFG_FULL_SCALE: r_full_scale <= i_cfg_data[vmt_pkg::CV_W-1:0];
                vmt_pkg::CFG_TOGGLE_KEY: r_toggle_key <= i_cfg_data[vmt_pkg::KEY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vmt_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_operation   (i_operation),
        .i_sample_code (i_sample_code),
        .i_key_code    (i_key_code),
        .i_toggle_key  (r_toggle_key),
        .o_cmd         (cmd),
        .o_cmd_code    (cmd_code),
        .i_cmd_pop     (cmd_pop)
    );

    vmt_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cmd_code     (cmd_code),
        .o_cmd_pop      (cmd_pop),
        .i_full_scale   (r_full_scale),
        .o_result       (result),
        .o_result_valid (result_valid),
        .i_result_pop   (pop)
    );

    // Result word onto the ports.
    assign empty                = !result_valid;
    assign o_mode               = result.mode;
    assign o_instant_valid      = result.instant_valid;
    assign o_stats_valid        = result.stats_valid;
    assign o_instant_centivolts = result.instant_cv;
    assign o_max_centivolts     = result.max_cv;
    assign o_min_centivolts     = result.min_cv;
    assign o_average_centivolts = result.average_cv;
    assign o_count_saturated    = result.count_saturated;

endmodule

FILE: hdl/vmt_checker.sv
// ----------------------------------------------------------------------------
// vmt_checker
// Port-level checks of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vmt_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [1:0]                  o_mode,
    input  logic                        o_instant_valid,
    input  logic                        o_stats_valid,
    input  logic [vmt_pkg::CV_W-1:0]    o_instant_centivolts,
    input  logic [vmt_pkg::CV_W-1:0]    o_max_centivolts,
    input  logic [vmt_pkg::CV_W-1:0]    o_min_centivolts,
    input  logic [vmt_pkg::CV_W-1:0]    o_average_centivolts,
    input  logic                        o_count_saturated
);

    // Reset leaves no result word behind.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown after reset");

    // A stalled result word holds still.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_mode)
                              && $stable(o_instant_centivolts)
                              && $stable(o_average_centivolts)))
        else $error("held result changed");

    // Statistics are shown only while running, and then the instant value too.
    a_stats_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_stats_valid) |->
            (o_mode == vmt_pkg::MODE_RUNNING && o_instant_valid))
        else $error("statistics shown outside running");

    // Hidden statistics read as zero.
    a_stats_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_stats_valid) |->
            (o_max_centivolts == '0 && o_min_centivolts == '0
             && o_average_centivolts == '0 && !o_count_saturated))
        else $error("hidden statistics not cleared");

    // The instant value shows only in running or paused.
    a_instant_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_instant_valid == (o_mode == vmt_pkg::MODE_RUNNING
                                        || o_mode == vmt_pkg::MODE_PAUSED)))
        else $error("instant flag disagrees with mode");

endmodule

bind voltmeter_min_max_average_tracker vmt_checker u_vmt_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .empty                (empty),
    .pop                  (pop),
    .o_mode               (o_mode),
    .o_instant_valid      (o_instant_valid),
    .o_stats_valid        (o_stats_valid),
    .o_instant_centivolts (o_instant_centivolts),
    .o_max_centivolts     (o_max_centivolts),
    .o_min_centivolts     (o_min_centivolts),
    .o_average_centivolts (o_average_centivolts),
    .o_count_saturated    (o_count_saturated)
);

FILE: test/tb_voltmeter_min_max_average_tracker.sv
// ----------------------------------------------------------------------------
// tb_voltmeter_min_max_average_tracker
// Self-checking testbench for the running min/max/average voltmeter tracker.
// ----------------------------------------------------------------------------
// The stimulus process fills a queue of input words and the driver offers them
// in bursts of random length with random gaps. Every accepted word is passed
// through a behavioural copy of the mode machine and the centivolt conversion,
// and the expected result word is queued. The monitor pops result words on a
// stall pattern of its own, at times holding off long enough for the block to
// fill and raise full, and compares each word field by field with the oldest
// expected one. Some phases open with one long run of a few hundred samples
// so that the running sum and average are taken over many samples. The
// registers are rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module tb_voltmeter_min_max_average_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 16;
    localparam longint unsigned CODE_FULL   = (64'd1 << SAMPLE_BITS) - 1;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_BITS) - 1;
    localparam logic OPERATION_KEY = ~vmt_pkg::OPERATION_SAMPLE;

    // Receiver hold-off, the cycles allowed after the drain, and the long run.
    localparam int unsigned HOLD_CYCLES      = 1500;
    localparam int unsigned HOLD_SPACING     = 900;
    localparam int unsigned DRAIN_CYCLES     = 100;
    localparam int unsigned SETTLE_CYCLES    = 8;
    localparam int unsigned LONG_RUN_SAMPLES = 250;

    // One input word as it stands on the input ports.
    typedef struct packed {
        logic                          operation;
        logic [SAMPLE_BITS-1:0]        sample_code;
        logic [vmt_pkg::KEY_W-1:0]     key_code;
    } t_word;

    // Block ports.
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            push = 1'b0;
    logic                            full;
    logic                            i_operation = vmt_pkg::OPERATION_SAMPLE;
    logic [SAMPLE_BITS-1:0]          i_sample_code = '0;
    logic [vmt_pkg::KEY_W-1:0]       i_key_code = vmt_pkg::KEY_NONE;
    logic                            empty;
    logic                            pop = 1'b0;
    logic [1:0]                      o_mode;
    logic                            o_instant_valid;
    logic                            o_stats_valid;
    logic [vmt_pkg::CV_W-1:0]        o_instant_centivolts;
    logic [vmt_pkg::CV_W-1:0]        o_max_centivolts;
    logic [vmt_pkg::CV_W-1:0]        o_min_centivolts;
    logic [vmt_pkg::CV_W-1:0]        o_average_centivolts;
    logic                            o_count_saturated;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [vmt_pkg::CFG_INDEX_W-1:0] i_cfg_index = vmt_pkg::CFG_FULL_SCALE;
    logic [vmt_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;

    // Tracker state as predicted, with its own copy of the registers.
    vmt_pkg::t_mode                  meter_mode = vmt_pkg::MODE_IDLE;
    logic [SAMPLE_BITS-1:0]          last_code = '0;
    logic [SAMPLE_BITS-1:0]          low_code = '0;
    logic [SAMPLE_BITS-1:0]          high_code = '0;
    longint unsigned                 code_sum = 0;
    longint unsigned                 code_count = 0;
    logic [vmt_pkg::CV_W-1:0]        full_scale = vmt_pkg::FULL_SCALE_RESET;
    logic [vmt_pkg::KEY_W-1:0]       toggle_key = vmt_pkg::TOGGLE_KEY_RESET;

    // Words waiting to be sent and readings waiting to come out.
    t_word            words_to_send[$];
    vmt_pkg::t_result readings_due[$];
    vmt_pkg::t_result due;

    // Handshake bookkeeping and the idling patterns of both sides.
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned results_taken = 0;
    int unsigned mismatches = 0;
    bit          word_taken = 1'b0;
    bit          result_taken = 1'b0;
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    int unsigned next_hold_at = 60;

    // Clock, period 10 ns.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    voltmeter_min_max_average_tracker #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_operation         (i_operation),
        .i_sample_code       (i_sample_code),
        .i_key_code          (i_key_code),
        .empty               (empty),
        .pop                 (pop),
        .o_mode              (o_mode),
        .o_instant_valid     (o_instant_valid),
        .o_stats_valid       (o_stats_valid),
        .o_instant_centivolts(o_instant_centivolts),
        .o_max_centivolts    (o_max_centivolts),
        .o_min_centivolts    (o_min_centivolts),
        .o_average_centivolts(o_average_centivolts),
        .o_count_saturated   (o_count_saturated),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want) begin
            report_mismatch($sformatf("result %0d, %s: got %0d, expected %0d",
                                      results_taken, name, got, want));
        end
    endtask

    // round(total * full_scale / (n * full code)), halves rounding up.
    function automatic logic [vmt_pkg::CV_W-1:0] to_centivolts(
            input longint unsigned total, input longint unsigned n);
        longint unsigned den;
        longint unsigned q;
        den = n * CODE_FULL;
        if (den == 0) return '0;
        q = (2 * total * full_scale + den) / (2 * den);
        return q[vmt_pkg::CV_W-1:0];
    endfunction

    // Moves the predicted tracker on by one word and queues the reading it shows.
    task automatic predict_reading(input t_word w);
        vmt_pkg::t_result r;
        logic             shown;
        if (w.operation == vmt_pkg::OPERATION_SAMPLE) begin
            case (meter_mode)
                vmt_pkg::MODE_ARMED: begin
                    last_code  = w.sample_code;
                    low_code   = w.sample_code;
                    high_code  = w.sample_code;
                    code_sum   = w.sample_code;
                    code_count = 1;
                    meter_mode = vmt_pkg::MODE_RUNNING;
                end
                vmt_pkg::MODE_RUNNING: begin
                    last_code = w.sample_code;
                    if (w.sample_code < low_code) low_code = w.sample_code;
                    if (w.sample_code > high_code) high_code = w.sample_code;
                    // Sum and count freeze once the counter is full.
                    if (code_count < COUNT_LIMIT) begin
                        code_sum += w.sample_code;
                        code_count++;
                    end
                end
                vmt_pkg::MODE_PAUSED: last_code = w.sample_code;
                default: ;
            endcase
        end else if (w.key_code != vmt_pkg::KEY_NONE && w.key_code == toggle_key) begin
            case (meter_mode) inside
                vmt_pkg::MODE_IDLE, vmt_pkg::MODE_PAUSED: meter_mode = vmt_pkg::MODE_ARMED;
                vmt_pkg::MODE_RUNNING: meter_mode = vmt_pkg::MODE_PAUSED;
                default: ;
            endcase
        end
        shown = (meter_mode == vmt_pkg::MODE_RUNNING) || (meter_mode == vmt_pkg::MODE_PAUSED);
        r.mode            = meter_mode;
        r.instant_valid   = shown;
        r.stats_valid     = (meter_mode == vmt_pkg::MODE_RUNNING);
        r.instant_cv      = shown ? to_centivolts(last_code, 1) : '0;
        r.max_cv          = r.stats_valid ? to_centivolts(high_code, 1) : '0;
        r.min_cv          = r.stats_valid ? to_centivolts(low_code, 1) : '0;
        r.average_cv      = r.stats_valid ? to_centivolts(code_sum, code_count) : '0;
        r.count_saturated = r.stats_valid && (code_count >= COUNT_LIMIT);
        readings_due.push_back(r);
    endtask

    // Samples lean towards both ends of the converter range.
    function automatic logic [SAMPLE_BITS-1:0] random_code();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return r[SAMPLE_BITS-1:0];
        endcase
    endfunction

    // Any 5-bit key, the toggle key often.
    function automatic logic [vmt_pkg::KEY_W-1:0] random_key();
        logic [31:0] r;
        r = $urandom;
        if ($urandom_range(0, 2) == 0) return toggle_key;
        return r[vmt_pkg::KEY_W-1:0];
    endfunction

    // The unused field of each word carries random bits.
    task automatic queue_sample(input logic [SAMPLE_BITS-1:0] code);
        t_word       w;
        logic [31:0] r;
        r = $urandom;
        w.operation   = vmt_pkg::OPERATION_SAMPLE;
        w.sample_code = code;
        w.key_code    = r[vmt_pkg::KEY_W-1:0];
        words_to_send.push_back(w);
        words_queued++;
    endtask

    task automatic queue_key(input logic [vmt_pkg::KEY_W-1:0] key);
        t_word       w;
        logic [31:0] r;
        r = $urandom;
        w.operation   = OPERATION_KEY;
        w.sample_code = r[SAMPLE_BITS-1:0];
        w.key_code    = key;
        words_to_send.push_back(w);
        words_queued++;
    endtask

    // Waits until every word has been sent and every reading has come out.
    task automatic settle();
        while (words_to_send.size() != 0 || readings_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [vmt_pkg::CFG_INDEX_W-1:0] index,
                                  input logic [vmt_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (index == vmt_pkg::CFG_FULL_SCALE) begin
            full_scale = data;
        end else begin
            toggle_key = data[vmt_pkg::KEY_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // One phase: new register settings, then mostly well-formed runs.
    task automatic run_phase(input logic [vmt_pkg::CV_W-1:0] scale,
                             input logic [vmt_pkg::KEY_W-1:0] key,
                             input int unsigned n_words, input bit long_run);
        logic [31:0] upper;
        int unsigned target;
        settle();
        write_register(vmt_pkg::CFG_FULL_SCALE, scale);
        upper = $urandom;
        write_register(vmt_pkg::CFG_TOGGLE_KEY,
                       {upper[vmt_pkg::CFG_DATA_W-vmt_pkg::KEY_W-1:0], key});
        target = words_queued + n_words;
        if (long_run) begin
            // Arm from whatever mode the last phase left, then one long run.
            if (meter_mode == vmt_pkg::MODE_RUNNING) queue_key(toggle_key);
            if (meter_mode != vmt_pkg::MODE_ARMED) queue_key(toggle_key);
            repeat (LONG_RUN_SAMPLES + $urandom_range(2, 20)) queue_sample(random_code());
            queue_key(toggle_key);
        end
        while (words_queued < target) begin
            if ($urandom_range(0, 9) < 7) begin
                // Toggle, samples with stray keys, toggle, then a few samples.
                queue_key(toggle_key);
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(0, 7) == 0) queue_key(random_key());
                    queue_sample(random_code());
                end
                queue_key(toggle_key);
                repeat ($urandom_range(0, 3)) queue_sample(random_code());
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    if ($urandom_range(0, 1) == 0) begin
                        queue_key(random_key());
                    end else begin
                        queue_sample(random_code());
                    end
                end
            end
        end
    endtask

    // Driver: offers queued words in bursts, holding each until it is taken.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !word_taken) begin
            // The word on offer stays until the block takes it.
        end else if (gap_left != 0) begin
            gap_left--;
            push <= 1'b0;
        end else if (words_to_send.size() != 0) begin
            push          <= 1'b1;
            i_operation   <= words_to_send[0].operation;
            i_sample_code <= words_to_send[0].sample_code;
            i_key_code    <= words_to_send[0].key_code;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                case ((words_taken / 150) % 3)
                    0: begin
                        burst_left = 64;
                        gap_left   = 0;
                    end
                    1: begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(0, 60);
                    end
                    default: begin
                        burst_left = $urandom_range(1, 3);
                        gap_left   = $urandom_range(20, 150);
                    end
                endcase
            end
        end else begin
            push <= 1'b0;
        end
    end

    // Receiver: stalls after popped words, and now and then holds off for long.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (words_to_send.size() != 0 && results_taken >= next_hold_at) begin
            // Long enough for the block to fill up and raise full.
            hold_left    = HOLD_CYCLES;
            next_hold_at = next_hold_at + HOLD_SPACING;
            pop <= 1'b0;
        end else begin
            if (result_taken) begin
                case ((results_taken / 170) % 3)
                    0: stall_left = 0;
                    1: stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : 0;
                    default: stall_left = $urandom_range(0, 150);
                endcase
            end
            if (stall_left != 0) begin
                stall_left--;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Monitor: checks popped words against the readings due, and predicts
    // the reading of every word the block takes.
    always @(posedge i_clk) begin
        word_taken   = 1'b0;
        result_taken = 1'b0;
        if (i_rst_n) begin
            if (pop && !empty) begin
                result_taken = 1'b1;
                results_taken++;
                if (readings_due.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_taken));
                end else begin
                    due = readings_due.pop_front();
                    check_field("mode", o_mode, due.mode);
                    check_field("instant_valid", o_instant_valid, due.instant_valid);
                    check_field("stats_valid", o_stats_valid, due.stats_valid);
                    check_field("instant_centivolts", o_instant_centivolts, due.instant_cv);
                    check_field("max_centivolts", o_max_centivolts, due.max_cv);
                    check_field("min_centivolts", o_min_centivolts, due.min_cv);
                    check_field("average_centivolts", o_average_centivolts, due.average_cv);
                    check_field("count_saturated", o_count_saturated, due.count_saturated);
                end
            end
            if (push && !full) begin
                word_taken = 1'b1;
                words_taken++;
                predict_reading(words_to_send.pop_front());
            end
        end
    end

    // Stimulus: reset, directed words, then random phases over several settings.
    initial begin
        logic [31:0] pick;
        logic [31:0] key_pick;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset settings.
        queue_sample('1);                   // idle ignores samples
        queue_key(vmt_pkg::KEY_NONE);       // no key never toggles
        queue_key(5'd5);                    // another key is ignored
        queue_key(toggle_key);              // arm
        queue_key(toggle_key);              // toggle while armed stays armed
        queue_sample('0);                   // first sample of a run
        queue_sample('1);
        queue_sample(10'd512);
        queue_sample(10'd1);
        queue_key(5'd16);
        queue_key(toggle_key);              // pause
        queue_sample(10'd700);              // paused: only the instant value moves
        queue_sample('0);
        queue_key(toggle_key);              // re-arm a fresh run
        queue_sample('1);
        queue_sample('1);
        queue_key(5'd31);
        queue_key(toggle_key);
        queue_sample(10'd341);
        queue_key(toggle_key);
        queue_sample(10'd341);
        queue_sample(10'd682);
        queue_key(toggle_key);

        run_phase(10'd999, 5'd1, 320, 1'b1);
        run_phase(10'd100, 5'd16, 300, 1'b0);
        // Zero full scale, and a toggle register of zero that nothing matches.
        run_phase(10'd0, vmt_pkg::KEY_NONE, 100, 1'b0);
        run_phase(10'd1023, 5'd31, 320, 1'b1);
        pick     = $urandom_range(100, 999);
        key_pick = $urandom_range(1, 16);
        run_phase(pick[vmt_pkg::CV_W-1:0], key_pick[vmt_pkg::KEY_W-1:0], 310, 1'b0);
        run_phase(vmt_pkg::FULL_SCALE_RESET, vmt_pkg::TOGGLE_KEY_RESET, 300, 1'b0);

        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!empty) begin
            report_mismatch("result word shown after the last expected one");
        end
        if (mismatches == 0) begin
            $display("PASS voltmeter_min_max_average_tracker");
        end else begin
            $display("FAIL voltmeter_min_max_average_tracker");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #20_000_000;
        $display("FAIL voltmeter_min_max_average_tracker");
        $finish;
    end

endmodule

FILE: voltmeter_min_max_average_tracker.f
hdl/vmt_pkg.sv
hdl/vmt_front.sv
hdl/vmt_div.sv
hdl/vmt_back.sv
hdl/voltmeter_min_max_average_tracker.sv
hdl/vmt_checker.sv
test/tb_voltmeter_min_max_average_tracker.sv
